>>> rtl/core/lcdw_pkg.sv
// Shared types and constants of the character LCD parallel write controller.
`timescale 1ns / 1ps
`default_nettype none

package lcdw_pkg;

    // Delay register width and its reset value (ticks per one-millisecond step)
    localparam int unsigned DELAY_W = 20;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd50000;

    // Stream payload widths
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;

    // Pin timing phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POLL_EN,
        PH_POLL_GAP,
        PH_SETUP,
        PH_STROBE
    } t_phase;

    // One decoded item, as queued between front and back
    typedef struct packed {
        logic       req;        // start a write request
        logic [7:0] data_byte;
        logic       is_char;
        logic       d7_level;
    } t_item;

    // Pin levels after one tick
    typedef struct packed {
        logic       en_pin;
        logic       rw_pin;
        logic       rs_pin;
        logic       d7_drive;
        logic [7:0] bus_data;
    } t_pins;

    // Pin levels after reset: all low, D7 driven
    localparam t_pins PINS_RESET = '{
        en_pin: 1'b0, rw_pin: 1'b0, rs_pin: 1'b0, d7_drive: 1'b1, bus_data: 8'h00
    };

endpackage

`default_nettype wire

>>> rtl/core/char_lcd_parallel_write_controller.sv
// Top level of the character LCD parallel write controller.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: cmd, is_char; tdata: data_byte, d7_level
//  m_axis   | out       | tdata: bus_data, d7_drive, rs_pin, rw_pin, en_pin, ready_res
//  cfg      | in        | delay_ticks, written whenever i_cfg_we is high
//
// One item in and one result out per cycle while m_axis_tready stays high; a taken
// item is written into the two-entry queue, and the engine then steps on it and
// loads its result into the output register, from which it can be taken.
// Reset sets the delay to 50000 ticks, the phase to idle and the pins low with
// D7 driven. A stall on the output side fills the queue, and tready drops only
// once both queue entries are held.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_parallel_write_controller
    import lcdw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Delay register
    input  wire logic                  i_cfg_we,
    input  wire logic [DELAY_W-1:0]    i_cfg_wdata,
    // Input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte, [8] d7_level
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,  // [0] cmd, [1] is_char
    // Output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] bus_data, [8] d7_drive, [9] rs_pin, [10] rw_pin, [11] en_pin, [12] ready_res
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic  item_valid;
    logic  item_pop;
    t_item item;

    // Accept and queue items
    lcdw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_item_pop    (item_pop)
    );

    // Run the pin timing
    lcdw_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_pop    (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/lcdw_front.sv
// Front part: accepts input items, decodes them and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none

module lcdw_front
    import lcdw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // [7:0] data_byte, [8] d7_level
    input  wire logic [IN_USER_W-1:0] s_axis_tuser,  // [0] cmd, [1] is_char
    // Queue read side
    output logic                      o_item_valid,
    output t_item                     o_item,
    input  wire logic                 i_item_pop
);

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       pop;
    t_item      item_in;

    // Decode the incoming item
    always_comb begin
        item_in.req       = s_axis_tuser[0];
        item_in.is_char   = s_axis_tuser[1];
        item_in.data_byte = s_axis_tdata[7:0];
        item_in.d7_level  = s_axis_tdata[8];
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_item_valid  = (r_count != 2'd0);
    assign pop           = i_item_pop && o_item_valid;
    assign o_item        = r_slot[r_rd_ptr];

    // Track the fill level
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Store the item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= item_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lcdw_engine.sv
// Back part: pin timing state machine, one queued item per tick, with output register.
`timescale 1ns / 1ps
`default_nettype none

module lcdw_engine
    import lcdw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Delay register write
    input  wire logic                  i_cfg_we,
    input  wire logic [DELAY_W-1:0]    i_cfg_wdata,
    // Queue read side
    input  wire logic                  i_item_valid,
    input  wire t_item                 i_item,
    output logic                       o_item_pop,
    // Output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [DELAY_W-1:0]    r_delay;
    t_phase                r_phase;
    t_phase                n_phase;
    logic [DELAY_W-1:0]    r_wait;
    logic [DELAY_W-1:0]    n_wait;
    logic [7:0]            r_held_byte;
    logic [7:0]            n_held_byte;
    logic                  r_held_is_char;
    logic                  n_held_is_char;
    logic                  r_busy_seen;
    logic                  n_busy_seen;
    t_pins                 r_pins;
    t_pins                 n_pins;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [DELAY_W-1:0]    limit;
    logic [DELAY_W-1:0]    wait_inc;
    logic                  active;
    logic                  done;
    logic                  step;

    // Take an item when the output slot is free or being emptied
    assign step       = i_item_valid && (!r_out_valid || m_axis_tready);
    assign o_item_pop = step;

    // Delay step end: a zero delay acts as one tick
    assign limit    = (r_delay == '0) ? DELAY_W'(1) : r_delay;
    assign active   = (r_phase != PH_IDLE);
    assign wait_inc = r_wait + DELAY_W'(1);
    assign done     = active && (wait_inc >= limit);

    // Next state and pin levels for one tick
    always_comb begin
        n_phase        = r_phase;
        n_wait         = active ? wait_inc : r_wait;
        n_held_byte    = r_held_byte;
        n_held_is_char = r_held_is_char;
        n_busy_seen    = r_busy_seen;
        n_pins         = r_pins;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.req) begin
                    n_held_byte     = i_item.data_byte;
                    n_held_is_char  = i_item.is_char;
                    n_pins.bus_data = r_pins.bus_data | 8'h80;
                    n_pins.rs_pin   = 1'b0;
                    n_pins.rw_pin   = 1'b1;
                    n_pins.d7_drive = 1'b0;
                    n_pins.en_pin   = 1'b1;
                    n_phase         = PH_POLL_EN;
                    n_wait          = '0;
                end
            end
            PH_POLL_EN: begin
                if (done) begin
                    n_busy_seen   = i_item.d7_level;
                    n_pins.en_pin = 1'b0;
                    n_phase       = PH_POLL_GAP;
                    n_wait        = '0;
                end
            end
            PH_POLL_GAP: begin
                if (done) begin
                    if (r_busy_seen) begin
                        n_pins.en_pin = 1'b1;
                        n_phase       = PH_POLL_EN;
                    end else begin
                        n_pins.d7_drive = 1'b1;
                        n_pins.rs_pin   = r_held_is_char;
                        n_pins.rw_pin   = 1'b0;
                        n_phase         = PH_SETUP;
                    end
                    n_wait = '0;
                end
            end
            PH_SETUP: begin
                if (done) begin
                    n_pins.bus_data = r_held_byte;
                    n_pins.en_pin   = 1'b1;
                    n_phase         = PH_STROBE;
                    n_wait          = '0;
                end
            end
            PH_STROBE: begin
                if (done) begin
                    n_pins.en_pin = 1'b0;
                    n_phase       = PH_IDLE;
                    n_wait        = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Hold the delay register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_wdata;
        end
    end

    // Advance the state machine one tick per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_wait         <= '0;
            r_held_byte    <= 8'h00;
            r_held_is_char <= 1'b0;
            r_busy_seen    <= 1'b0;
            r_pins         <= PINS_RESET;
        end else if (step) begin
            r_phase        <= n_phase;
            r_wait         <= n_wait;
            r_held_byte    <= n_held_byte;
            r_held_is_char <= n_held_is_char;
            r_busy_seen    <= n_busy_seen;
            r_pins         <= n_pins;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result: pins, then the idle flag, zero padded
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {3'b000, (n_phase == PH_IDLE), n_pins};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the character LCD parallel write controller.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import lcdw_pkg::*;

    // Handshake idling patterns
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    // Cycles without any handshake on either stream before the run is declared hung
    localparam int HANG_LIMIT = 1000;

    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

    // Expected pin levels after one tick
    typedef struct {
        t_pins pins;
        logic  ready;
    } t_pin_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [DELAY_W-1:0]     i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;  // [7:0] data_byte, [8] d7_level
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;  // [0] cmd, [1] is_char
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] bus_data, [8] d7_drive, [9] rs_pin, [10] rw_pin, [11] en_pin, [12] ready_res
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // Ticks waiting to be sent and pin levels waiting to come back
    t_item       tick_queue[$];
    t_pin_result pins_expected[$];
    t_item       tick_on_bus;
    int unsigned ticks_queued = 0;
    int unsigned ticks_taken = 0;
    int unsigned mismatch_count = 0;
    int          idle_mode = IDLE_NONE;
    int unsigned hang_cycles = 0;

    // Shadow of the pin timing state
    logic [DELAY_W-1:0] tick_delay = DELAY_RESET;
    t_phase             lcd_phase = PH_IDLE;
    logic [DELAY_W-1:0] lcd_wait = '0;
    logic [7:0]         lcd_held_byte = '0;
    logic               lcd_held_char = 1'b0;
    logic               lcd_busy_seen = 1'b0;
    t_pins              lcd_pins = PINS_RESET;

    char_lcd_parallel_write_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Advance the shadow pin timing by one tick and queue the pin levels it gives
    task automatic advance_lcd_timing(input t_item tick);
        logic [DELAY_W-1:0] limit;
        logic               done;
        limit = (tick_delay == '0) ? DELAY_W'(1) : tick_delay;
        done = 1'b0;
        if (lcd_phase != PH_IDLE) begin
            lcd_wait = lcd_wait + 1'b1;
            done = (lcd_wait >= limit);
        end
        case (lcd_phase)
            PH_IDLE: begin
                if (tick.req) begin
                    lcd_held_byte = tick.data_byte;
                    lcd_held_char = tick.is_char;
                    lcd_pins.bus_data[7] = 1'b1;
                    lcd_pins.rs_pin = 1'b0;
                    lcd_pins.rw_pin = 1'b1;
                    lcd_pins.d7_drive = 1'b0;
                    lcd_pins.en_pin = 1'b1;
                    lcd_phase = PH_POLL_EN;
                    lcd_wait = '0;
                end
            end
            PH_POLL_EN: begin
                if (done) begin
                    lcd_busy_seen = tick.d7_level;
                    lcd_pins.en_pin = 1'b0;
                    lcd_phase = PH_POLL_GAP;
                    lcd_wait = '0;
                end
            end
            PH_POLL_GAP: begin
                if (done) begin
                    if (lcd_busy_seen) begin
                        lcd_pins.en_pin = 1'b1;
                        lcd_phase = PH_POLL_EN;
                    end else begin
                        lcd_pins.d7_drive = 1'b1;
                        lcd_pins.rs_pin = lcd_held_char;
                        lcd_pins.rw_pin = 1'b0;
                        lcd_phase = PH_SETUP;
                    end
                    lcd_wait = '0;
                end
            end
            PH_SETUP: begin
                if (done) begin
                    lcd_pins.bus_data = lcd_held_byte;
                    lcd_pins.en_pin = 1'b1;
                    lcd_phase = PH_STROBE;
                    lcd_wait = '0;
                end
            end
            default: begin
                if (done) begin
                    lcd_pins.en_pin = 1'b0;
                    lcd_phase = PH_IDLE;
                    lcd_wait = '0;
                end
            end
        endcase
        pins_expected.push_back('{pins: lcd_pins, ready: (lcd_phase == PH_IDLE)});
    endtask

    function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Send ticks from the queue, holding each one until it is taken
    always @(posedge i_clk) begin : tick_driver
        logic  taken;
        logic  hold_off;
        t_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            taken = s_axis_tvalid && s_axis_tready;
            if (taken) begin
                advance_lcd_timing(tick_on_bus);
                ticks_taken++;
            end
            hold_off = (idle_mode == IDLE_SEND && $urandom_range(99) < 88) ||
                       (idle_mode == IDLE_BOTH && $urandom_range(99) < 28);
            if (s_axis_tvalid && !taken) begin
                s_axis_tvalid <= 1'b1;
            end else if (tick_queue.size() > 0 && !hold_off) begin
                nxt = tick_queue.pop_front();
                tick_on_bus = nxt;
                s_axis_tdata <= {7'b0, nxt.d7_level, nxt.data_byte};
                s_axis_tuser <= {nxt.is_char, nxt.req};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Compare each returned pin set with the oldest expectation
    always @(posedge i_clk) begin : pin_monitor
        t_pin_result exp_r;
        logic        stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pins_expected.size() == 0) begin
                    $error("pin result %0h with nothing expected", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    exp_r = pins_expected.pop_front();
                    check_field("bus_data", exp_r.pins.bus_data, m_axis_tdata[7:0]);
                    check_field("d7_drive", exp_r.pins.d7_drive, m_axis_tdata[8]);
                    check_field("rs_pin", exp_r.pins.rs_pin, m_axis_tdata[9]);
                    check_field("rw_pin", exp_r.pins.rw_pin, m_axis_tdata[10]);
                    check_field("en_pin", exp_r.pins.en_pin, m_axis_tdata[11]);
                    check_field("ready_res", exp_r.ready, m_axis_tdata[12]);
                end
            end
            stall = (idle_mode == IDLE_RECV && $urandom_range(99) < 88) ||
                    (idle_mode == IDLE_BOTH && $urandom_range(99) < 28);
            m_axis_tready <= !stall;
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            hang_cycles <= 0;
        end else if (hang_cycles >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    task automatic push_tick(input logic req, input logic [7:0] byte_v,
                             input logic chr, input logic d7);
        t_item it;
        it.req = req;
        it.data_byte = byte_v;
        it.is_char = chr;
        it.d7_level = d7;
        tick_queue.push_back(it);
        ticks_queued++;
    endtask

    // Mostly plain ticks with the odd write request; busy flag mostly clear
    task automatic push_random_ticks(input int unsigned count);
        repeat (count) begin
            push_tick($urandom_range(7) == 0, 8'($urandom), 1'($urandom),
                      $urandom_range(3) == 0);
        end
    endtask

    task automatic wait_drained();
        while (ticks_taken != ticks_queued || pins_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] value);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        tick_delay = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [DELAY_W-1:0] value, input int mode,
                                    input int unsigned count);
        write_delay(value);
        idle_mode = mode;
        push_random_ticks(count);
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset delay: a request that stays in the first poll, plus one while busy
        push_tick(1'b0, 8'hA5, 1'b1, 1'b1);
        push_tick(1'b1, 8'hFF, 1'b1, 1'b0);
        push_tick(1'b0, 8'h00, 1'b0, 1'b1);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        push_tick(1'b0, 8'hFF, 1'b1, 1'b0);
        push_tick(1'b1, 8'h00, 1'b0, 1'b0);
        wait_drained();

        // Zero delay acts as one tick: busy once, then finish the write of 0xFF
        write_delay('0);
        push_tick(1'b0, 8'h00, 1'b0, 1'b1);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        // Idle: bus keeps the last byte
        push_tick(1'b0, 8'h3C, 1'b1, 1'b1);
        // Command 0x00, with a request while busy in the setup step
        push_tick(1'b1, 8'h00, 1'b0, 1'b1);
        push_tick(1'b0, 8'hFF, 1'b1, 1'b0);
        push_tick(1'b0, 8'hFF, 1'b1, 1'b0);
        push_tick(1'b1, 8'hAA, 1'b1, 1'b0);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        // Released D7 shows high on the bus over a zero byte
        push_tick(1'b1, 8'h55, 1'b1, 1'b0);
        push_tick(1'b0, 8'h00, 1'b0, 1'b1);
        push_tick(1'b0, 8'h00, 1'b0, 1'b1);
        push_tick(1'b0, 8'h00, 1'b0, 1'b0);
        wait_drained();

        // Longest delay: writes never complete
        run_random_phase(DELAY_MAX, IDLE_BOTH, 20);

        run_random_phase(20'd1, IDLE_NONE, 228);
        run_random_phase(20'd2, IDLE_SEND, 228);
        run_random_phase(20'd3, IDLE_RECV, 228);
        run_random_phase(20'd0, IDLE_BOTH, 228);
        run_random_phase(20'd5, IDLE_NONE, 228);
        run_random_phase(20'd1, IDLE_SEND, 228);
        run_random_phase(20'd2, IDLE_RECV, 228);
        run_random_phase(20'd3, IDLE_BOTH, 228);

        idle_mode = IDLE_NONE;
        repeat (8) @(posedge i_clk);
        if (pins_expected.size() != 0) begin
            $error("%0d pin results never arrived", pins_expected.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
